// ===== src/ufb_pkg.sv =====
// ufb_pkg: shared types and constants for the uart frame builder
// no dependencies; compiled first

package ufb_pkg;

	// largest payload length a header may announce; longer requests are clamped
	localparam int unsigned MAX_PAYLOAD = 251;

	localparam logic [7:0] SYNC_BYTE = 8'h5A;

	// most bytes one request produces (sync, id, two length bytes, checksum)
	localparam int unsigned MAX_RESULTS = 5;

	// result queue: one byte still waiting plus the bytes of a new request
	localparam int unsigned QUEUE_DEPTH = MAX_RESULTS + 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		REQ_HEADER  = 1'b0,
		REQ_PAYLOAD = 1'b1
	} ufb_req_kind_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_end;
	} ufb_res_t;

endpackage

// ===== src/ufb_if.sv =====
// ufb_if: valid/ready channel interfaces for the uart frame builder
// request channel (header or payload items) and result channel (bytes out)

interface ufb_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] message_id;
	logic [7:0] payload_len;
	logic [7:0] payload_byte;

	modport source (output valid, req_type, message_id, payload_len, payload_byte,
		input ready);
	modport sink (input valid, req_type, message_id, payload_len, payload_byte,
		output ready);
endinterface

interface ufb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       frame_end;

	modport source (output valid, tx_byte, frame_end, input ready);
	modport sink (input valid, tx_byte, frame_end, output ready);
endinterface

// ===== src/uart_frame_builder_unit.sv =====
// uart_frame_builder_unit: byte-wise transmit framer with additive checksum
// depends on ufb_pkg and the channel interfaces in ufb_if.sv
//
// usage
//   req channel: one transfer per item. a header item (req_type = 0) opens a
//   frame with message_id and payload_len; a payload item (req_type = 1)
//   carries one payload_byte. payload items outside a frame are taken and
//   dropped. a header inside an open frame abandons it without a checksum.
//   rsp channel: one transfer per output byte. a header yields 0x5A, id and
//   (len+1) as two big-endian bytes, then the inverted 8-bit checksum with
//   frame_end set if len is zero. a payload item yields its byte, followed by
//   the checksum with frame_end on the last payload byte of the frame.
//   order: the first byte of an item is on rsp in the cycle after its transfer
//   when nothing older is queued, else right behind the one older byte.
//   throughput: one output byte per cycle while rsp.ready is high, set by the
//   single rsp port; a payload item yields one or two bytes, a header four or
//   five. req is taken whenever at most one older byte is still queued after
//   this cycle, so a new item overlaps the last byte of the previous one.
//   stall: when rsp.ready is low the queued bytes hold, and req.ready drops
//   once more than one byte is waiting.
//   reset: arst_n clears the queue and closes any open frame; no clearing
//   pass is needed.

module uart_frame_builder_unit (
	input  logic      clk,
	input  logic      arst_n,
	ufb_req_if.sink   req,
	ufb_rsp_if.source rsp
);
	import ufb_pkg::*;

	// frame state
	logic       in_frame_q;
	logic [7:0] bytes_left_q;
	logic [7:0] running_sum_q;

	// result queue, entry 0 drives the rsp channel
	ufb_res_t            queue_q [QUEUE_DEPTH];
	logic [QCNT_W-1:0]   qcnt_q;

	logic                req_xfer;
	logic                rsp_xfer;
	logic [QCNT_W-1:0]   qbase;     // entries left after this cycle's output transfer
	ufb_res_t            shifted [QUEUE_DEPTH];
	ufb_res_t            new_res [MAX_RESULTS];
	logic [QCNT_W-1:0]   new_cnt;

	logic                in_frame_d;
	logic [7:0]          bytes_left_d;
	logic [7:0]          running_sum_d;

	// header arithmetic
	logic [15:0]         len_clamped;
	logic [7:0]          len8;
	logic [8:0]          flen;
	logic [7:0]          len_hi;
	logic [7:0]          len_lo;
	logic [7:0]          hdr_sum;

	// payload arithmetic
	logic [7:0]          pay_sum;
	logic [7:0]          pay_left;

	assign rsp_xfer  = rsp.valid && rsp.ready;
	assign qbase     = qcnt_q - QCNT_W'(rsp_xfer);
	assign req.ready = (qbase <= QCNT_W'(1));
	assign req_xfer  = req.valid && req.ready;

	assign rsp.valid     = (qcnt_q != '0);
	assign rsp.tx_byte   = queue_q[0].tx_byte;
	assign rsp.frame_end = queue_q[0].frame_end;

	// clamp the announced length and form the big-endian length field
	assign len_clamped = (16'(req.payload_len) > 16'(MAX_PAYLOAD)) ?
		16'(MAX_PAYLOAD) : 16'(req.payload_len);
	assign len8    = len_clamped[7:0];
	assign flen    = {1'b0, len8} + 9'd1;
	assign len_hi  = {7'b0, flen[8]};
	assign len_lo  = flen[7:0];
	assign hdr_sum = req.message_id + len_hi + len_lo;

	assign pay_sum  = running_sum_q + req.payload_byte;
	assign pay_left = (bytes_left_q != '0) ? bytes_left_q - 8'd1 : 8'd0;

	// what one request produces and how it moves the frame state
	always_comb begin
		in_frame_d    = in_frame_q;
		bytes_left_d  = bytes_left_q;
		running_sum_d = running_sum_q;
		new_cnt       = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			new_res[i] = '{tx_byte: 8'h00, frame_end: 1'b0};
		end
		unique case (ufb_req_kind_t'(req.req_type))
			REQ_HEADER: begin
				new_res[0]    = '{tx_byte: SYNC_BYTE, frame_end: 1'b0};
				new_res[1]    = '{tx_byte: req.message_id, frame_end: 1'b0};
				new_res[2]    = '{tx_byte: len_hi, frame_end: 1'b0};
				new_res[3]    = '{tx_byte: len_lo, frame_end: 1'b0};
				new_res[4]    = '{tx_byte: ~hdr_sum, frame_end: 1'b1};
				running_sum_d = hdr_sum;
				bytes_left_d  = len8;
				if (len8 == '0) begin
					// empty frame closes at once
					new_cnt    = QCNT_W'(5);
					in_frame_d = 1'b0;
				end else begin
					new_cnt    = QCNT_W'(4);
					in_frame_d = 1'b1;
				end
			end
			REQ_PAYLOAD: begin
				// stray payload outside a frame is dropped with no effect
				if (in_frame_q) begin
					new_res[0]    = '{tx_byte: req.payload_byte, frame_end: 1'b0};
					new_res[1]    = '{tx_byte: ~pay_sum, frame_end: 1'b1};
					running_sum_d = pay_sum;
					bytes_left_d  = pay_left;
					if (pay_left == '0) begin
						new_cnt    = QCNT_W'(2);
						in_frame_d = 1'b0;
					end else begin
						new_cnt    = QCNT_W'(1);
					end
				end
			end
			default: begin
				new_cnt = '0;
			end
		endcase
	end

	// shift out the transferred byte, then append at the first free slot
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
			shifted[i] = rsp_xfer ? queue_q[i+1] : queue_q[i];
		end
		shifted[QUEUE_DEPTH-1] = queue_q[QUEUE_DEPTH-1];
		if (req_xfer) begin
			// qbase is zero or one whenever a request is taken
			for (int j = 0; j < MAX_RESULTS; j++) begin
				if (qbase == '0) begin
					shifted[j] = new_res[j];
				end else begin
					shifted[j+1] = new_res[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			queue_q[i] <= shifted[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q        <= '0;
			in_frame_q    <= 1'b0;
			bytes_left_q  <= '0;
			running_sum_q <= '0;
		end else begin
			qcnt_q <= qbase + (req_xfer ? new_cnt : QCNT_W'(0));
			if (req_xfer) begin
				in_frame_q    <= in_frame_d;
				bytes_left_q  <= bytes_left_d;
				running_sum_q <= running_sum_d;
			end
		end
	end

endmodule

// ===== src/ufb_checker.sv =====
// ufb_checker: port-level assertions for uart_frame_builder_unit
// bound to the top level below; uses only the channel handshake and payload

module ufb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       req_type,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_tx_byte,
	input logic       rsp_frame_end
);
	import ufb_pkg::*;

	// a stalled result keeps valid up
	a_rsp_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	// a stalled result keeps its byte and end mark
	a_rsp_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_tx_byte) && $stable(rsp_frame_end))
		else $error("rsp payload changed while stalled");

	// a header always produces output in the next cycle
	a_header_output: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == REQ_HEADER) |=> rsp_valid)
		else $error("header transfer without following output");

	// req only backs off while bytes are queued
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("req stalled with empty output queue");

endmodule

bind uart_frame_builder_unit ufb_checker u_ufb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_type      (req.req_type),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_tx_byte   (rsp.tx_byte),
	.rsp_frame_end (rsp.frame_end)
);
